### rtl/g2rc_pkg.sv
// Shared constants, register codes and the quarter-wave sine generator for the rainbow colormap.
`timescale 1ns / 1ps
`default_nettype none

package g2rc_pkg;

	// Default widths
	localparam int unsigned GRAY_BITS_DEF       = 16;
	localparam int unsigned CHANNEL_BITS_DEF    = 8;
	localparam int unsigned PHASE_FRAC_BITS_DEF = 10;

	// Sine table format: unsigned Q16, 1.0 needs a 17th bit
	localparam int unsigned SINE_FRAC = 16;
	localparam int unsigned SINE_BITS = SINE_FRAC + 1;
	localparam logic [SINE_BITS-1:0] SINE_ONE = SINE_BITS'(1) << SINE_FRAC;

	// pi/2 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_BITS = 2;
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_GRAY_LOW        = 2'd0,
		CFG_GRAY_HIGH       = 2'd1,
		CFG_CHANNEL_FLOOR   = 2'd2,
		CFG_CHANNEL_CEILING = 2'd3
	} cfg_index_t;

	// sin(idx * pi/2 / 2^frac) in Q16. Taylor series to x^11 in Q30, each
	// product truncated, rounded to Q16 and clamped. Elaboration only.
	function automatic logic [SINE_BITS-1:0] sine_q16(input logic [31:0] idx,
	                                                  input int unsigned frac);
		logic [63:0] full;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] r;
		logic signed [63:0] sum;
		full = 64'd1 << frac;
		if (idx == 32'd0) begin
			return '0;
		end
		if (64'(idx) >= full) begin
			return SINE_ONE;
		end
		x    = (64'(idx) * HALF_PI_Q30) >> frac;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - $signed(term);
		if (sum < 0) begin
			return '0;
		end
		r = ($unsigned(sum) + 64'd8192) >> 14;
		if (r > 64'(SINE_ONE)) begin
			return SINE_ONE;
		end
		return r[SINE_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/gray_to_rainbow_colormap.sv
// Gray to rainbow colormap: clamp, normalize by a bit-serial pipelined divider, sine ramp, RGB out.
`timescale 1ns / 1ps
`default_nettype none
// The divider is pipelined, one quotient bit per stage (PHASE_FRAC_BITS + 3 stages).
// Throughput: one pixel per cycle; every stage advances together while the output skid
//   register is empty, so one stalled result plus one more in flight are absorbed.
// Reset (arst_n low, asynchronous): all valid bits clear, config registers go to
//   gray_low 0, gray_high all ones, channel_floor 0, channel_ceiling all ones.
// Config writes are always taken (cfg_ready tied high) and must only happen while idle.

module gray_to_rainbow_colormap #(
	parameter int unsigned GRAY_BITS       = g2rc_pkg::GRAY_BITS_DEF,
	parameter int unsigned CHANNEL_BITS    = g2rc_pkg::CHANNEL_BITS_DEF,
	parameter int unsigned PHASE_FRAC_BITS = g2rc_pkg::PHASE_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,

	// Pixel input. tdata: gray [GRAY_BITS-1:0], zero padding above.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [((GRAY_BITS+7)/8)*8-1:0]      s_axis_tdata,

	// Color output. tdata: red, green, blue (CHANNEL_BITS each, red lowest), zero padding.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [((3*CHANNEL_BITS+7)/8)*8-1:0] m_axis_tdata,

	// Register write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  g2rc_pkg::cfg_index_t                cfg_index,
	input  logic [(GRAY_BITS > CHANNEL_BITS ? GRAY_BITS : CHANNEL_BITS)-1:0] cfg_data
);

	import g2rc_pkg::*;

	localparam int unsigned G          = GRAY_BITS;
	localparam int unsigned CB         = CHANNEL_BITS;
	localparam int unsigned FB         = PHASE_FRAC_BITS;
	localparam int unsigned QB         = FB + 3;          // quotient bits: t <= 6 * 2^FB
	localparam int unsigned SINE_DEPTH = (1 << FB) + 1;   // phases 0 .. 2^FB inclusive
	localparam int unsigned PIX_W      = 3 * CB;
	localparam int unsigned OUT_TDATA_W = ((3*CHANNEL_BITS+7)/8)*8;
	localparam logic [FB:0] PHASE_FULL = (FB+1)'(1) << FB;

	// Segment codes: held channel at ceiling, and which channel ramps which way
	typedef enum logic [2:0] {
		SEG_R_BDN = 3'd0,   // R=C, G=F, B falls
		SEG_R_GUP = 3'd1,   // R=C, G rises, B=F
		SEG_G_RDN = 3'd2,   // R falls, G=C, B=F
		SEG_G_BUP = 3'd3,   // R=F, G=C, B rises
		SEG_B_GDN = 3'd4,   // R=F, G falls, B=C
		SEG_B_RUP = 3'd5    // R rises, G=F, B=C
	} seg_t;

	typedef logic [SINE_DEPTH-1:0][SINE_BITS-1:0] sine_rom_t;

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int i = 0; i < int'(SINE_DEPTH); i++) begin
			rom[i] = sine_q16(32'(i), FB);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [G-1:0]  gray_low_q;
	logic [G-1:0]  gray_high_q;
	logic [CB-1:0] chan_floor_q;
	logic [CB-1:0] chan_ceil_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_low_q   <= '0;
			gray_high_q  <= '1;
			chan_floor_q <= '0;
			chan_ceil_q  <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GRAY_LOW:        gray_low_q   <= cfg_data[G-1:0];
				CFG_GRAY_HIGH:       gray_high_q  <= cfg_data[G-1:0];
				CFG_CHANNEL_FLOOR:   chan_floor_q <= cfg_data[CB-1:0];
				CFG_CHANNEL_CEILING: chan_ceil_q  <= cfg_data[CB-1:0];
				default: ;
			endcase
		end
	end

	// Ramp amplitude; an inverted channel range gives a flat ramp
	logic [CB-1:0] span;
	assign span = (chan_ceil_q > chan_floor_q) ? (chan_ceil_q - chan_floor_q) : '0;

	// ------------------------------------------------------------------
	// Pipeline enable: everything moves while the skid slot is free
	// ------------------------------------------------------------------
	logic skid_vld_q;
	logic en;
	assign en            = !skid_vld_q;
	assign s_axis_tready = en;

	// ------------------------------------------------------------------
	// Stage 1: clamp and offset
	// ------------------------------------------------------------------
	logic         v_s1;
	logic         ok_s1;
	logic [G-1:0] a_s1;
	logic [G-1:0] d_s1;
	logic [G-1:0] gray_in;
	logic [G-1:0] gray_clamp;

	assign gray_in    = s_axis_tdata[G-1:0];
	assign gray_clamp = (gray_in < gray_low_q)  ? gray_low_q  :
	                    (gray_in > gray_high_q) ? gray_high_q : gray_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1 <= gray_high_q > gray_low_q;
			a_s1  <= gray_clamp - gray_low_q;
			d_s1  <= gray_high_q - gray_low_q;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2 and divider stages. Entry 0 is the prep stage: a*6, with
	// the top bits as the first partial remainder (a*6 < 8*d keeps it below d).
	// Entry k holds the state after k quotient bits.
	// ------------------------------------------------------------------
	logic          div_v_s3   [QB+1];
	logic          div_ok_s3  [QB+1];
	logic [G-1:0]  div_rem_s3 [QB+1];
	logic [G-1:0]  div_d_s3   [QB+1];
	logic [QB-1:0] div_x_s3   [QB+1];   // remaining dividend bits, MSB next
	logic [QB-1:0] div_q_s3   [QB+1];
	logic [G+2:0]  a6;

	assign a6 = ((G+3)'(a_s1) << 2) + ((G+3)'(a_s1) << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s3[0] <= 1'b0;
		end else if (en) begin
			div_v_s3[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_ok_s3[0]  <= ok_s1;
			div_rem_s3[0] <= a6[G+2:3];
			div_d_s3[0]   <= d_s1;
			div_x_s3[0]   <= {a6[2:0], FB'(0)};
			div_q_s3[0]   <= '0;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_div
		logic [G:0] trial;
		logic [G:0] diff;
		logic       ge;

		assign trial = {div_rem_s3[k-1], div_x_s3[k-1][QB-1]};
		assign diff  = trial - {1'b0, div_d_s3[k-1]};
		assign ge    = trial >= {1'b0, div_d_s3[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s3[k] <= 1'b0;
			end else if (en) begin
				div_v_s3[k] <= div_v_s3[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_ok_s3[k]  <= div_ok_s3[k-1];
				div_rem_s3[k] <= ge ? diff[G-1:0] : trial[G-1:0];
				div_d_s3[k]   <= div_d_s3[k-1];
				div_x_s3[k]   <= div_x_s3[k-1] << 1;
				div_q_s3[k]   <= {div_q_s3[k-1][QB-2:0], ge};
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: segment and phase
	// ------------------------------------------------------------------
	logic          v_s4;
	seg_t          seg_s4;
	logic [FB:0]   idx_up_s4;
	logic [FB:0]   idx_dn_s4;
	logic [QB-1:0] t_pos;
	logic [2:0]    seg_raw;
	seg_t          seg_nxt;
	logic [FB:0]   idx_up_nxt;

	assign t_pos   = div_q_s3[QB];
	assign seg_raw = t_pos[QB-1:FB];

	always_comb begin
		if (!div_ok_s3[QB]) begin
			// empty gray range
			seg_nxt    = SEG_R_BDN;
			idx_up_nxt = '0;
		end else if (seg_raw > 3'(SEG_B_RUP)) begin
			// top of range: last segment at full phase
			seg_nxt    = SEG_B_RUP;
			idx_up_nxt = PHASE_FULL;
		end else begin
			seg_nxt    = seg_t'(seg_raw);
			idx_up_nxt = {1'b0, t_pos[FB-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= div_v_s3[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s4    <= seg_nxt;
			idx_up_s4 <= idx_up_nxt;
			idx_dn_s4 <= PHASE_FULL - idx_up_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: sine table reads, rising and falling
	// ------------------------------------------------------------------
	logic                 v_s5;
	seg_t                 seg_s5;
	logic [SINE_BITS-1:0] sin_up_s5;
	logic [SINE_BITS-1:0] sin_dn_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s5    <= seg_s4;
			sin_up_s5 <= SINE_ROM[idx_up_s4];
			sin_dn_s5 <= SINE_ROM[idx_dn_s4];
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: scale by channel span
	// ------------------------------------------------------------------
	logic                    v_s6;
	seg_t                    seg_s6;
	logic [SINE_BITS+CB-1:0] mul_up_s6;
	logic [SINE_BITS+CB-1:0] mul_dn_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s6    <= seg_s5;
			mul_up_s6 <= (SINE_BITS+CB)'(sin_up_s5) * (SINE_BITS+CB)'(span);
			mul_dn_s6 <= (SINE_BITS+CB)'(sin_dn_s5) * (SINE_BITS+CB)'(span);
		end
	end

	// ------------------------------------------------------------------
	// Channel select, feeding the output register
	// ------------------------------------------------------------------
	logic [CB-1:0]    ramp_up;
	logic [CB-1:0]    ramp_dn;
	logic [PIX_W-1:0] pix_nxt;   // {blue, green, red}

	assign ramp_up = chan_floor_q + mul_up_s6[SINE_FRAC +: CB];
	assign ramp_dn = chan_floor_q + mul_dn_s6[SINE_FRAC +: CB];

	always_comb begin
		case (seg_s6)
			SEG_R_BDN: pix_nxt = {ramp_dn,      chan_floor_q, chan_ceil_q};
			SEG_R_GUP: pix_nxt = {chan_floor_q, ramp_up,      chan_ceil_q};
			SEG_G_RDN: pix_nxt = {chan_floor_q, chan_ceil_q,  ramp_dn};
			SEG_G_BUP: pix_nxt = {ramp_up,      chan_ceil_q,  chan_floor_q};
			SEG_B_GDN: pix_nxt = {chan_ceil_q,  ramp_dn,      chan_floor_q};
			SEG_B_RUP: pix_nxt = {chan_ceil_q,  chan_floor_q, ramp_up};
			default:   pix_nxt = {ramp_up,      chan_floor_q, chan_ceil_q};
		endcase
	end

	// ------------------------------------------------------------------
	// Output register plus skid slot
	// ------------------------------------------------------------------
	logic             out_vld_q;
	logic [PIX_W-1:0] out_pix_q;
	logic [PIX_W-1:0] skid_pix_q;
	logic             out_stalled;

	assign out_stalled = out_vld_q && !m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_axis_tready) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (out_stalled) begin
			skid_vld_q <= v_s6;
		end else begin
			out_vld_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (m_axis_tready) begin
				out_pix_q <= skid_pix_q;
			end
		end else if (out_stalled) begin
			skid_pix_q <= pix_nxt;
		end else begin
			out_pix_q <= pix_nxt;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_pix_q);

endmodule

`default_nettype wire

### rtl/g2rc_check.sv
// Port-level checks for the rainbow colormap, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module g2rc_check #(
	parameter int unsigned OUT_W = 24
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata,
	input logic             cfg_ready
);

	// A stalled result holds its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	// Input back-pressure only ever comes from a stalled output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("input not ready without an output stall");

	// While the input is held off, a result is on offer
	a_ready_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input not ready with no result pending");

	// Register writes never wait
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config channel not ready");

endmodule

bind gray_to_rainbow_colormap g2rc_check #(
	.OUT_W(OUT_TDATA_W)
) u_g2rc_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_ready     (cfg_ready)
);

`default_nettype wire
